>>> rtl/ghbp_pkg.sv
package ghbp_pkg;

	localparam int NUM_TABLES   = 8;
	localparam int INDEX_BITS   = 11;
	localparam int COUNTER_BITS = 4;
	localparam int MIN_HISTORY  = 3;
	localparam int HISTORY_BITS = 64;

	localparam int SEL_TABLE       = 6;
	localparam int ALIAS_BITS      = 9;
	localparam int TRAIN_BITS      = 7;
	localparam int ALIAS_MISS_STEP = -4;
	localparam int THETA_BITS      = 8;
	localparam int SUM_BITS        = 9;

	localparam logic REQ_PREDICT = 1'b0;
	localparam logic REQ_UPDATE  = 1'b1;

	typedef struct packed {
		logic                       req_type;
		logic [31:0]                pc;
		logic                       real_outcome;
		logic                       predicted_outcome;
		logic signed [SUM_BITS-1:0] update_sum;
	} item_t;

	typedef struct packed {
		logic                       taken;
		logic signed [SUM_BITS-1:0] pred_sum;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);

	// Q16 power of the ratio, starting at the minimum length
	function automatic longint unsigned pow_q16(longint unsigned r, int n,
			longint unsigned cap, int minh);
		longint unsigned v;
		v = longint'(minh) << 16;
		for (int k = 0; k < n; k++) begin
			v = (v * r) >> 16;
			if (v > cap) return cap + 1;
		end
		return v;
	endfunction

	// Geometric history length of slot i, fixed at elaboration
	function automatic int hist_len(int i, int nt, int minh, int hb);
		longint unsigned cap;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned v;
		longint unsigned l;
		cap = longint'(hb) << 16;
		lo  = 65536;
		hi  = 65536 * 8;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (pow_q16(mid, nt + 2, cap, minh) <= cap) lo = mid;
			else hi = mid - 1;
		end
		if (i == 0) return 0;
		if (i == nt + 3) return hb;
		v = pow_q16(lo, i - 1, cap, minh);
		l = (v + 32768) >> 16;
		if (l > longint'(hb)) l = longint'(hb);
		return int'(l);
	endfunction

endpackage

>>> rtl/ghbp_fifo.sv
module ghbp_fifo #(
	parameter int WIDTH = ghbp_pkg::ITEM_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

>>> rtl/ghbp_back.sv
module ghbp_back #(
	parameter int NUM_TABLES   = ghbp_pkg::NUM_TABLES,
	parameter int INDEX_BITS   = ghbp_pkg::INDEX_BITS,
	parameter int COUNTER_BITS = ghbp_pkg::COUNTER_BITS,
	parameter int MIN_HISTORY  = ghbp_pkg::MIN_HISTORY,
	parameter int HISTORY_BITS = ghbp_pkg::HISTORY_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_empty,
	input  logic [ghbp_pkg::ITEM_W-1:0] in_item,
	output logic                        in_pop,
	input  logic                        out_full,
	output logic                        out_push,
	output ghbp_pkg::result_t           out_res
);

	localparam int TS = 1 << INDEX_BITS;
	localparam int SB = ghbp_pkg::SUM_BITS;
	localparam int AB = ghbp_pkg::ALIAS_BITS;
	localparam int TB = ghbp_pkg::TRAIN_BITS;
	localparam int HB = ghbp_pkg::THETA_BITS;
	localparam logic signed [COUNTER_BITS-1:0] CMAX = {1'b0, {(COUNTER_BITS-1){1'b1}}};
	localparam logic signed [COUNTER_BITS-1:0] CMIN = {1'b1, {(COUNTER_BITS-1){1'b0}}};
	localparam logic signed [COUNTER_BITS-1:0] CSTEP = COUNTER_BITS'(1);

	typedef enum logic [1:0] {ST_CLR, ST_IDLE, ST_EXE} state_t;

	state_t                         state_q;
	logic [INDEX_BITS-1:0]          clr_q;
	logic [HISTORY_BITS-1:0]        hist_q;
	logic                           long_q;
	logic [HB-1:0]                  theta_q;
	logic signed [TB-1:0]           trainer_q;
	logic signed [AB-1:0]           meter_q;
	ghbp_pkg::item_t                item_s1;
	ghbp_pkg::item_t                head;
	logic [INDEX_BITS-1:0]          idx [NUM_TABLES];
	logic [INDEX_BITS-1:0]          idx_s1 [NUM_TABLES];
	logic [INDEX_BITS-1:0]          mask_s [NUM_TABLES];
	logic [INDEX_BITS-1:0]          mask_l [NUM_TABLES];
	logic [INDEX_BITS-1:0]          aidx;
	logic [INDEX_BITS-1:0]          aidx_s1;
	logic signed [COUNTER_BITS-1:0] cnt_s1 [NUM_TABLES];
	logic signed [COUNTER_BITS-1:0] cnt_new [NUM_TABLES];
	logic                           tag_s1;
	logic                           clearing;
	logic                           rd_en;
	logic                           cnt_we;
	logic                           tag_we;
	logic signed [SB-1:0]           sum;
	logic signed [SB-1:0]           usum;
	logic [SB-1:0]                  mag;
	logic                           is_upd;
	logic                           miss;
	logic                           low_conf;
	logic signed [AB:0]             meter_ext;
	logic signed [AB-1:0]           meter_nxt;
	logic signed [TB:0]             trn_ext;
	logic signed [TB-1:0]           trn_sat;

	localparam int LA = ghbp_pkg::hist_len(ghbp_pkg::SEL_TABLE, NUM_TABLES, MIN_HISTORY,
		HISTORY_BITS);
	localparam logic [INDEX_BITS-1:0] MASK_A = (LA >= INDEX_BITS) ? {INDEX_BITS{1'b1}} :
		INDEX_BITS'((1 << LA) - 1);

	assign head     = ghbp_pkg::item_t'(in_item);
	assign clearing = (state_q == ST_CLR);
	assign rd_en    = (state_q == ST_IDLE) && !in_empty && !out_full;
	assign in_pop   = rd_en;
	assign aidx     = head.pc[INDEX_BITS-1:0] ^ (hist_q[INDEX_BITS-1:0] & MASK_A);

	generate
		for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tbl
			localparam int LS = ghbp_pkg::hist_len(t, NUM_TABLES, MIN_HISTORY, HISTORY_BITS);
			localparam int SLOT = (t == 2) ? NUM_TABLES + 1 : (t == 4) ? NUM_TABLES + 2 :
				(t == 6) ? NUM_TABLES + 3 : t;
			localparam int LL = ghbp_pkg::hist_len(SLOT, NUM_TABLES, MIN_HISTORY,
				HISTORY_BITS);
			localparam logic [INDEX_BITS-1:0] MS = (LS >= INDEX_BITS) ?
				{INDEX_BITS{1'b1}} : INDEX_BITS'((1 << LS) - 1);
			localparam logic [INDEX_BITS-1:0] ML = (LL >= INDEX_BITS) ?
				{INDEX_BITS{1'b1}} : INDEX_BITS'((1 << LL) - 1);

			logic signed [COUNTER_BITS-1:0] tbl_q [TS];
			logic [INDEX_BITS-1:0]          wa;
			logic signed [COUNTER_BITS-1:0] wd;

			assign mask_s[t] = MS;
			assign mask_l[t] = ML;
			assign idx[t]    = head.pc[INDEX_BITS-1:0] ^
				(hist_q[INDEX_BITS-1:0] & (long_q ? mask_l[t] : mask_s[t]));
			assign wa        = clearing ? clr_q : idx_s1[t];
			assign wd        = clearing ? '0 : cnt_new[t];

			always_ff @(posedge clk) begin
				if (clearing || cnt_we) tbl_q[wa] <= wd;
				if (rd_en) begin
					cnt_s1[t] <= tbl_q[idx[t]];
					idx_s1[t] <= idx[t];
				end
			end

			always_comb begin
				cnt_new[t] = cnt_s1[t];
				if (item_s1.real_outcome) begin
					if (cnt_s1[t] != CMAX) cnt_new[t] = cnt_s1[t] + CSTEP;
				end else begin
					if (cnt_s1[t] != CMIN) cnt_new[t] = cnt_s1[t] - CSTEP;
				end
			end
		end
	endgenerate

	// alias tag store
	logic tag_mem [TS];
	always_ff @(posedge clk) begin
		if (clearing) tag_mem[clr_q] <= 1'b0;
		else if (tag_we) tag_mem[aidx_s1] <= item_s1.pc[0];
		if (rd_en) begin
			tag_s1  <= tag_mem[aidx];
			aidx_s1 <= aidx;
		end
	end

	always_comb begin
		sum = '0;
		for (int t = 0; t < NUM_TABLES; t++) sum = sum + SB'(cnt_s1[t]);
	end

	assign usum     = item_s1.update_sum;
	assign mag      = usum[SB-1] ? SB'(-usum) : SB'(usum);
	assign is_upd   = (item_s1.req_type == ghbp_pkg::REQ_UPDATE);
	assign miss     = item_s1.real_outcome != item_s1.predicted_outcome;
	assign low_conf = mag <= {1'b0, theta_q};
	assign cnt_we   = (state_q == ST_EXE) && is_upd && (miss || low_conf);
	assign tag_we   = (state_q == ST_EXE) && is_upd && miss && low_conf;

	assign out_push         = (state_q == ST_EXE) && !is_upd;
	assign out_res.taken    = !sum[SB-1];
	assign out_res.pred_sum = sum;

	always_comb begin
		meter_ext = {meter_q[AB-1], meter_q} + ((tag_s1 == item_s1.pc[0]) ?
			(AB+1)'(1) : (AB+1)'(ghbp_pkg::ALIAS_MISS_STEP));
		if (meter_ext > $signed({2'b00, {(AB-1){1'b1}}})) meter_nxt = {1'b0, {(AB-1){1'b1}}};
		else if (meter_ext < $signed({2'b11, {(AB-1){1'b0}}}))
			meter_nxt = {1'b1, {(AB-1){1'b0}}};
		else meter_nxt = meter_ext[AB-1:0];
	end

	always_comb begin
		trn_ext = {trainer_q[TB-1], trainer_q} + (miss ? (TB+1)'(1) : -(TB+1)'(1));
		if (trn_ext > $signed({2'b00, {(TB-1){1'b1}}})) trn_sat = {1'b0, {(TB-1){1'b1}}};
		else if (trn_ext < $signed({2'b11, {(TB-1){1'b0}}}))
			trn_sat = {1'b1, {(TB-1){1'b0}}};
		else trn_sat = trn_ext[TB-1:0];
	end

	always_ff @(posedge clk) begin
		if (rd_en) item_s1 <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			hist_q    <= '0;
			long_q    <= 1'b0;
			theta_q   <= HB'(NUM_TABLES);
			trainer_q <= '0;
			meter_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {INDEX_BITS{1'b1}}) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (rd_en) state_q <= ST_EXE;
				end
				ST_EXE: begin
					state_q <= ST_IDLE;
					if (is_upd) begin
						if (miss && low_conf) begin
							meter_q <= meter_nxt;
							if (meter_nxt == {1'b0, {(AB-1){1'b1}}}) long_q <= 1'b1;
							else if (meter_nxt == {1'b1, {(AB-1){1'b0}}}) long_q <= 1'b0;
						end
						if (miss) begin
							if (trn_sat == {1'b0, {(TB-1){1'b1}}}) begin
								trainer_q <= '0;
								if (theta_q != {HB{1'b1}}) theta_q <= theta_q + 1'b1;
							end else trainer_q <= trn_sat;
						end else if (low_conf) begin
							if (trn_sat == {1'b1, {(TB-1){1'b0}}}) begin
								trainer_q <= '0;
								if (theta_q != '0) theta_q <= theta_q - 1'b1;
							end else trainer_q <= trn_sat;
						end
						hist_q <= {hist_q[HISTORY_BITS-2:0], item_s1.real_outcome};
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/geometric_history_branch_predictor.sv
// Geometric-history branch predictor with queue-style ports on both sides.
// Path: an item leaves the input queue into the back end's stage-one registers;
// from the execute state a prediction is pushed into the result queue.
// The back end takes no new item until the counter read-modify-write is done.
// Reset: after arst_n the back end sweeps all 2^INDEX_BITS table entries to
// zero, one per cycle; pushes queue up (two deep) and wait for the sweep.
module geometric_history_branch_predictor #(
	parameter int NUM_TABLES   = ghbp_pkg::NUM_TABLES,
	parameter int INDEX_BITS   = ghbp_pkg::INDEX_BITS,
	parameter int COUNTER_BITS = ghbp_pkg::COUNTER_BITS,
	parameter int MIN_HISTORY  = ghbp_pkg::MIN_HISTORY,
	parameter int HISTORY_BITS = ghbp_pkg::HISTORY_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              req_type,
	input  logic [31:0]       pc,
	input  logic              real_outcome,
	input  logic              predicted_outcome,
	input  logic signed [8:0] update_sum,
	output logic              empty,
	input  logic              pop,
	output logic              taken,
	output logic signed [8:0] pred_sum
);

	ghbp_pkg::item_t                     in_item;
	logic [ghbp_pkg::ITEM_W-1:0]         q_item;
	logic                                q_empty;
	logic                                q_pop;
	logic                                res_full;
	logic                                res_push;
	ghbp_pkg::result_t                   res;
	logic [ghbp_pkg::RESULT_W-1:0]       res_dout;
	ghbp_pkg::result_t                   res_head;

	// Pack the beat; the back end decodes predict versus update.
	assign in_item.req_type          = req_type;
	assign in_item.pc                = pc;
	assign in_item.real_outcome      = real_outcome;
	assign in_item.predicted_outcome = predicted_outcome;
	assign in_item.update_sum        = update_sum;

	// Front: hold incoming beats so the back end can stall on its own.
	ghbp_fifo #(
		.WIDTH(ghbp_pkg::ITEM_W)
	) u_inq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (in_item),
		.full  (full),
		.pop   (q_pop),
		.dout  (q_item),
		.empty (q_empty)
	);

	// Back: table lookup, sum, training and history advance.
	ghbp_back #(
		.NUM_TABLES  (NUM_TABLES),
		.INDEX_BITS  (INDEX_BITS),
		.COUNTER_BITS(COUNTER_BITS),
		.MIN_HISTORY (MIN_HISTORY),
		.HISTORY_BITS(HISTORY_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_empty(q_empty),
		.in_item (q_item),
		.in_pop  (q_pop),
		.out_full(res_full),
		.out_push(res_push),
		.out_res (res)
	);

	// Result queue: hold predictions until the consumer pops them.
	ghbp_fifo #(
		.WIDTH(ghbp_pkg::RESULT_W)
	) u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_dout),
		.empty (empty)
	);

	assign res_head = ghbp_pkg::result_t'(res_dout);
	assign taken    = res_head.taken;
	assign pred_sum = res_head.pred_sum;

endmodule

>>> tb/sv/geometric_history_branch_predictor_checker.sv
`timescale 1ns / 1ps

module geometric_history_branch_predictor_checker
	import ghbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic              req_type,
	input  logic [31:0]       pc,
	input  logic              real_outcome,
	input  logic              predicted_outcome,
	input  logic signed [8:0] update_sum,
	input  logic              empty,
	input  logic              pop,
	input  logic              taken,
	input  logic signed [8:0] pred_sum,
	output int                fail_count,
	output int                pending
);

	localparam int TBL_SIZE = 1 << INDEX_BITS;
	localparam int NUM_LENS = NUM_TABLES + 4;

	logic signed [COUNTER_BITS-1:0] ctr [NUM_TABLES][TBL_SIZE];
	logic                           tags [TBL_SIZE];
	logic [HISTORY_BITS-1:0]        ghist;
	int                             theta_q;
	int                             trainer_q;
	int                             meter_q;
	logic                           long_on;
	int                             len_of [NUM_LENS];
	result_t                        sums_q[$];

	// Q16 series of geometric history lengths, built here from scratch
	function automatic longint unsigned geo_pow(longint unsigned r, int n);
		longint unsigned v;
		longint unsigned cap;
		cap = longint'(HISTORY_BITS) << 16;
		v = longint'(MIN_HISTORY) << 16;
		for (int k = 0; k < n; k++) begin
			v = (v * r) >> 16;
			if (v > cap) return cap + 1;
		end
		return v;
	endfunction

	function automatic int clamp(int v, int bits);
		int hi;
		hi = (1 << (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic int slot_of(int t);
		if (long_on) begin
			if (t == 2) return NUM_TABLES + 1;
			if (t == 4) return NUM_TABLES + 2;
			if (t == 6) return NUM_TABLES + 3;
		end
		return t;
	endfunction

	function automatic int hashed_index(int t, logic [31:0] a, int len);
		logic [63:0] h;
		h = 0;
		if (t != 0) begin
			h = 64'(ghist);
			if (len < 64) h = h & ((64'd1 << len) - 64'd1);
		end
		return int'((64'(a) ^ h) & 64'(TBL_SIZE - 1));
	endfunction

	initial begin
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned l;
		lo = 65536;
		hi = 65536 * 8;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (geo_pow(mid, NUM_TABLES + 2) <= (longint'(HISTORY_BITS) << 16)) lo = mid;
			else hi = mid - 1;
		end
		len_of[0] = 0;
		for (int i = 1; i < NUM_LENS; i++) begin
			l = (geo_pow(lo, i - 1) + 32768) >> 16;
			if (l > HISTORY_BITS) l = HISTORY_BITS;
			len_of[i] = int'(l);
		end
		len_of[NUM_LENS-1] = HISTORY_BITS;
	end

	assign pending = sums_q.size();

	// Apply one update beat to the predictor state
	task automatic train(logic [31:0] a, logic outcome, logic guess, logic signed [8:0] s);
		int  mag;
		bit  miss;
		bit  low_conf;
		int  ix;
		int  amax;
		miss = outcome != guess;
		mag = (s < 0) ? -int'(s) : int'(s);
		low_conf = mag <= theta_q;
		if (miss || low_conf) begin
			for (int t = 0; t < NUM_TABLES; t++) begin
				ix = hashed_index(t, a, len_of[slot_of(t)]);
				ctr[t][ix] = clamp(int'(ctr[t][ix]) + (outcome ? 1 : -1), COUNTER_BITS);
			end
		end
		if (miss && low_conf) begin
			ix = hashed_index(SEL_TABLE, a, len_of[SEL_TABLE]);
			amax = (1 << (ALIAS_BITS - 1)) - 1;
			meter_q = clamp(meter_q + ((tags[ix] == a[0]) ? 1 : ALIAS_MISS_STEP), ALIAS_BITS);
			tags[ix] = a[0];
			if (meter_q == amax) long_on = 1'b1;
			else if (meter_q == -amax - 1) long_on = 1'b0;
		end
		if (miss) begin
			trainer_q = clamp(trainer_q + 1, TRAIN_BITS);
			if (trainer_q == (1 << (TRAIN_BITS - 1)) - 1) begin
				if (theta_q < (1 << THETA_BITS) - 1) theta_q++;
				trainer_q = 0;
			end
		end else if (low_conf) begin
			trainer_q = clamp(trainer_q - 1, TRAIN_BITS);
			if (trainer_q == -(1 << (TRAIN_BITS - 1))) begin
				if (theta_q > 0) theta_q--;
				trainer_q = 0;
			end
		end
		ghist = {ghist[HISTORY_BITS-2:0], outcome};
	endtask

	function automatic result_t lookup(logic [31:0] a);
		int      s;
		result_t r;
		s = 0;
		for (int t = 0; t < NUM_TABLES; t++)
			s += int'(ctr[t][hashed_index(t, a, len_of[slot_of(t)])]);
		r.taken = s >= 0;
		r.pred_sum = s[8:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int t = 0; t < NUM_TABLES; t++)
				for (int i = 0; i < TBL_SIZE; i++) ctr[t][i] = '0;
			for (int i = 0; i < TBL_SIZE; i++) tags[i] = 1'b0;
			ghist = '0;
			theta_q = NUM_TABLES;
			trainer_q = 0;
			meter_q = 0;
			long_on = 1'b0;
			sums_q.delete();
			fail_count = 0;
		end else begin
			// Compare the popped beat first; it reflects state before this edge
			if (pop && !empty) begin
				if (sums_q.size() == 0) begin
					$display("%0t: unexpected result taken=%0b sum=%0d", $time, taken, pred_sum);
					fail_count++;
				end else begin
					want = sums_q.pop_front();
					if (taken !== want.taken) begin
						$display("%0t: taken expected %0b actual %0b", $time, want.taken, taken);
						fail_count++;
					end
					if (pred_sum !== want.pred_sum) begin
						$display("%0t: pred_sum expected %0d actual %0d", $time,
							want.pred_sum, pred_sum);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				if (req_type == REQ_PREDICT) sums_q.push_back(lookup(pc));
				else train(pc, real_outcome, predicted_outcome, update_sum);
			end
		end
	end

endmodule

>>> tb/sv/geometric_history_branch_predictor_tb.sv
`timescale 1ns / 1ps

module geometric_history_branch_predictor_tb;
	import ghbp_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam longint CYCLE_LIMIT = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              req_type = REQ_PREDICT;
	logic [31:0]       pc = '0;
	logic              real_outcome = 1'b0;
	logic              predicted_outcome = 1'b0;
	logic signed [8:0] update_sum = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic              taken;
	logic signed [8:0] pred_sum;
	int                fail_count;
	int                pending;

	// Idle percentages per phase; the stall window holds pop low for a long run
	int     push_idle_pct = 22;
	int     pop_idle_pct = 56;
	bit     pop_hold = 1'b0;
	longint cycles = 0;

	always #2 clk = ~clk;

	geometric_history_branch_predictor dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .pc(pc), .real_outcome(real_outcome),
		.predicted_outcome(predicted_outcome), .update_sum(update_sum),
		.empty(empty), .pop(pop), .taken(taken), .pred_sum(pred_sum)
	);

	geometric_history_branch_predictor_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .pc(pc), .real_outcome(real_outcome),
		.predicted_outcome(predicted_outcome), .update_sum(update_sum),
		.empty(empty), .pop(pop), .taken(taken), .pred_sum(pred_sum),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver: random pop, forced low during the hold-off window
	always @(posedge clk) begin
		if (arst_n)
			pop <= !pop_hold && ($urandom_range(99) >= pop_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offer one beat and hold it until accepted; the next send or the caller drops push
	task automatic send(logic rt, logic [31:0] a, logic ro, logic po, logic signed [8:0] s);
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req_type <= rt;
		pc <= a;
		real_outcome <= ro;
		predicted_outcome <= po;
		update_sum <= s;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Predict then resolve a branch, feeding back a sum near theta so training is frequent
	task automatic branch_pair(logic [31:0] a);
		logic              dir;
		logic              guess;
		logic signed [8:0] s;
		dir = $urandom_range(1);
		guess = $urandom_range(3) == 0 ? !dir : dir;
		s = 9'($signed($urandom_range(40)) - 20);
		send(REQ_PREDICT, a, $urandom_range(1), $urandom_range(1), 9'($urandom));
		send(REQ_UPDATE, a, dir, guess, s);
	endtask

	task automatic random_phase(int n);
		logic [31:0] a;
		for (int i = 0; i < n; i += 2) begin
			// Hot branch set so counters saturate and aliases recur
			a = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(63)) * 4 + $urandom_range(1);
			if ($urandom_range(9) == 0)
				send($urandom_range(1), $urandom(), $urandom_range(1), $urandom_range(1),
					9'($urandom));
			else
				branch_pair(a);
		end
		push <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, both operations, ignored fields on predict
		send(REQ_PREDICT, 32'h0, 1'b1, 1'b0, -9'sd256);
		send(REQ_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1, 9'sd255);
		send(REQ_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b0, -9'sd256);
		send(REQ_UPDATE, 32'h0, 1'b0, 1'b1, 9'sd255);
		send(REQ_UPDATE, 32'hAAAA_5555, 1'b1, 1'b1, 9'sd0);
		send(REQ_UPDATE, 32'h5555_AAAA, 1'b0, 1'b0, 9'sd8);
		send(REQ_UPDATE, 32'h1234_5678, 1'b1, 1'b1, 9'sd9);
		send(REQ_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0, 9'sd0);
		send(REQ_PREDICT, 32'h0, 1'b0, 1'b0, 9'sd0);
		// Repeated misses at one pc drive counters to their limits
		for (int i = 0; i < 12; i++) send(REQ_UPDATE, 32'h40, 1'b1, 1'b0, 9'sd0);
		send(REQ_PREDICT, 32'h40, 1'b0, 1'b0, 9'sd0);
		// High pc bits with the same low bits must index identically
		send(REQ_PREDICT, 32'hFFFF_F840, 1'b0, 1'b0, 9'sd0);

		// Phase one, with a long receiver hold-off so the block backs up
		pop_hold = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				pop_hold = 1'b0;
			end
			random_phase(RANDOM_ITEMS / 3);
		join

		push_idle_pct = 56;
		pop_idle_pct = 22;
		random_phase(RANDOM_ITEMS / 3);

		push_idle_pct = 0;
		pop_idle_pct = 0;
		random_phase(RANDOM_ITEMS / 3);

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/ghbp_pkg.sv
rtl/ghbp_fifo.sv
rtl/ghbp_back.sv
rtl/geometric_history_branch_predictor.sv
tb/sv/geometric_history_branch_predictor_checker.sv
tb/sv/geometric_history_branch_predictor_tb.sv
